// File: rtl/core/hkm_pkg.sv
// Shared types, constants and command/status bundles for the k-way merge heap.
package hkm_pkg;

    localparam int HKM_MAX_SOURCES = 16;
    localparam int KEY_W           = 32;
    localparam int RUN_W           = 4;
    localparam int RUN_SLOTS       = 16;
    localparam int OFFSET_W        = 32;
    localparam int POS_W           = 32;

    typedef enum logic [1:0] {
        CMD_CLEAR       = 2'd0,
        CMD_INSERT      = 2'd1,
        CMD_POP_REPLACE = 2'd2,
        CMD_POP_REMOVE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd                cmd;
        logic [KEY_W-1:0]    key;
        logic [RUN_W-1:0]    run_number;
        logic [OFFSET_W-1:0] start_offset;
    } t_in;

    typedef struct packed {
        logic                emit_valid;
        logic [KEY_W-1:0]    out_key;
        logic [RUN_W-1:0]    out_run;
        logic [OFFSET_W-1:0] out_offset;
        logic [POS_W-1:0]    out_position;
        logic [RUN_W-1:0]    fetch_run;
        logic                heap_empty;
        t_status             status;
    } t_out;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [RUN_W-1:0] run;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_RM_RD,
        S_RM_LD,
        S_FIN
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic start;
        logic up_rd;
        logic up_cmp;
        logic dn_rd;
        logic dn_cmp;
        logic rm_rd;
        logic rm_ld;
        logic fin;
    } t_dp_op;

    // datapath -> controller
    typedef struct packed {
        logic go_up;
        logic go_dn;
        logic go_rm;
        logic up_at_root;
        logic up_stop;
        logic dn_leaf;
        logic dn_stop;
        logic out_free;
    } t_dp_sts;

endpackage

// File: rtl/core/hkm_ctrl.sv
// Sequencer for the merge heap: accept, sift up / sift down steps, result hand-off.
module hkm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  hkm_pkg::t_dp_sts i_sts,
    output logic             o_in_stall,
    output hkm_pkg::t_dp_op  o_op
);
    import hkm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_sts.go_up) n_state = S_UP_RD;
                    else if (i_sts.go_dn)     n_state = S_DN_RD;
                    else if (i_sts.go_rm)     n_state = S_RM_RD;
                    else                      n_state = S_FIN;
                end
            end
            S_UP_RD:  n_state = i_sts.up_at_root ? S_FIN : S_UP_CMP;
            S_UP_CMP: n_state = i_sts.up_stop ? S_FIN : S_UP_RD;
            S_DN_RD:  n_state = i_sts.dn_leaf ? S_FIN : S_DN_CMP;
            S_DN_CMP: n_state = i_sts.dn_stop ? S_FIN : S_DN_RD;
            S_RM_RD:  n_state = S_RM_LD;
            S_RM_LD:  n_state = S_DN_RD;
            S_FIN:    n_state = i_sts.out_free ? S_IDLE : S_FIN;
            default:  n_state = S_IDLE;
        endcase
    end

    // input held off while reset is asserted and whenever the sequencer is not idle
    always_comb begin
        o_op       = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = !i_rst_n;
                o_op.start = i_in_valid && i_rst_n;
            end
            S_UP_RD:  o_op.up_rd  = 1'b1;
            S_UP_CMP: o_op.up_cmp = 1'b1;
            S_DN_RD:  o_op.dn_rd  = 1'b1;
            S_DN_CMP: o_op.dn_cmp = 1'b1;
            S_RM_RD:  o_op.rm_rd  = 1'b1;
            S_RM_LD:  o_op.rm_ld  = 1'b1;
            S_FIN:    o_op.fin    = 1'b1;
            default:  o_op        = '0;
        endcase
    end

endmodule

// File: rtl/core/hkm_datapath.sv
// Heap memory, root shadow, per-run offsets, counters and the result register.
module hkm_datapath #(
    parameter int MAX_SOURCES = hkm_pkg::HKM_MAX_SOURCES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hkm_pkg::t_in     i_in,
    input  hkm_pkg::t_dp_op  i_op,
    output hkm_pkg::t_dp_sts o_sts,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output hkm_pkg::t_out    o_out
);
    import hkm_pkg::*;

    localparam int IW  = $clog2(MAX_SOURCES);
    localparam int CW  = $clog2(MAX_SOURCES + 1);
    localparam int CHW = IW + 2;
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_SOURCES);

    t_entry r_mem [MAX_SOURCES];
    t_entry r_rd_a;
    t_entry r_rd_b;
    t_entry r_root;
    t_entry r_hold;

    logic [OFFSET_W-1:0] r_offset [RUN_SLOTS];

    logic [CW-1:0]    r_count;
    logic [POS_W-1:0] r_emitted;
    logic [IW-1:0]    r_pos;
    t_out             r_pend;
    t_out             r_out;
    logic             r_out_valid;

    logic [IW-1:0]       w_pos_m1;
    logic [IW-1:0]       w_parent;
    logic [CHW-1:0]      w_c;
    logic [CHW-1:0]      w_c1;
    logic [CHW-1:0]      w_n;
    logic                w_right_ok;
    logic                w_pick_right;
    t_entry              w_child;
    logic [IW-1:0]       w_child_idx;
    logic                w_empty;
    logic                w_full;
    logic [OFFSET_W-1:0] w_root_off;
    logic [IW-1:0]       w_rd_addr_a;
    logic [IW-1:0]       w_rd_addr_b;
    logic                w_we;
    t_entry              w_wd;
    t_out                w_pend;
    t_out                w_out;

    assign w_pos_m1     = r_pos - IW'(1);
    assign w_parent     = w_pos_m1 >> 1;
    assign w_c          = {1'b0, r_pos, 1'b1};
    assign w_c1         = w_c + CHW'(1);
    assign w_n          = CHW'(r_count);
    assign w_right_ok   = w_c1 < w_n;
    // ties go left; right only when the left key is strictly greater
    assign w_pick_right = w_right_ok && (r_rd_a.key > r_rd_b.key);
    assign w_child      = w_pick_right ? r_rd_b : r_rd_a;
    assign w_child_idx  = w_pick_right ? w_c1[IW-1:0] : w_c[IW-1:0];
    assign w_empty      = r_count == '0;
    assign w_full       = r_count == FULL_COUNT;
    assign w_root_off   = r_offset[r_root.run];

    always_comb begin
        o_sts            = '0;
        o_sts.go_up      = (i_in.cmd == CMD_INSERT) && !w_full;
        o_sts.go_dn      = (i_in.cmd == CMD_POP_REPLACE) && !w_empty;
        o_sts.go_rm      = (i_in.cmd == CMD_POP_REMOVE) && !w_empty;
        o_sts.up_at_root = r_pos == '0;
        o_sts.up_stop    = r_rd_a.key <= r_hold.key;
        o_sts.dn_leaf    = w_c >= w_n;
        o_sts.dn_stop    = w_child.key > r_hold.key;
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    // hole-style sifting: the moving entry stays in r_hold, one write per level
    always_comb begin
        w_we = 1'b0;
        w_wd = r_hold;
        if (i_op.up_rd && o_sts.up_at_root) begin
            w_we = 1'b1;
        end
        if (i_op.up_cmp) begin
            w_we = 1'b1;
            w_wd = o_sts.up_stop ? r_hold : r_rd_a;
        end
        if (i_op.dn_rd && o_sts.dn_leaf) begin
            w_we = 1'b1;
        end
        if (i_op.dn_cmp) begin
            w_we = 1'b1;
            w_wd = o_sts.dn_stop ? r_hold : w_child;
        end
    end

    always_comb begin
        priority if (i_op.up_rd) w_rd_addr_a = w_parent;
        else if (i_op.rm_rd)     w_rd_addr_a = r_count[IW-1:0];
        else                     w_rd_addr_a = w_c[IW-1:0];
        w_rd_addr_b = w_c1[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_pos] <= w_wd;
        end
        r_rd_a <= r_mem[w_rd_addr_a];
        r_rd_b <= r_mem[w_rd_addr_b];
    end

    // root copy kept beside the memory so pops need no memory read
    always_ff @(posedge i_clk) begin
        if (w_we && (r_pos == '0)) begin
            r_root <= w_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.start) begin
            if (i_in.cmd == CMD_INSERT && !w_full) begin
                r_offset[i_in.run_number] <= i_in.start_offset;
            end else if ((i_in.cmd == CMD_POP_REPLACE || i_in.cmd == CMD_POP_REMOVE)
                         && !w_empty) begin
                r_offset[r_root.run] <= w_root_off + OFFSET_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_emitted <= '0;
        end else if (i_op.start) begin
            unique case (i_in.cmd)
                CMD_CLEAR: begin
                    r_count   <= '0;
                    r_emitted <= '0;
                end
                CMD_INSERT: begin
                    if (!w_full) begin
                        r_count <= r_count + CW'(1);
                    end
                end
                CMD_POP_REPLACE: begin
                    if (!w_empty) begin
                        r_emitted <= r_emitted + POS_W'(1);
                    end
                end
                CMD_POP_REMOVE: begin
                    if (!w_empty) begin
                        r_emitted <= r_emitted + POS_W'(1);
                        r_count   <= r_count - CW'(1);
                    end
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    // result fields known at accept time
    always_comb begin
        w_pend = '0;
        unique case (i_in.cmd)
            CMD_CLEAR: begin
                w_pend.status = ST_OK;
            end
            CMD_INSERT: begin
                if (w_full) begin
                    w_pend.status = ST_FULL;
                end
            end
            CMD_POP_REPLACE, CMD_POP_REMOVE: begin
                if (w_empty) begin
                    w_pend.status = ST_EMPTY;
                end else begin
                    w_pend.emit_valid   = 1'b1;
                    w_pend.out_key      = r_root.key;
                    w_pend.out_run      = r_root.run;
                    w_pend.out_offset   = w_root_off;
                    w_pend.out_position = r_emitted;
                end
            end
            default: begin
                w_pend.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_op.start) begin
            r_pend <= w_pend;
            if (o_sts.go_up) begin
                r_hold <= '{key: i_in.key, run: i_in.run_number};
                r_pos  <= r_count[IW-1:0];
            end else if (o_sts.go_dn || o_sts.go_rm) begin
                r_pos  <= '0;
                r_hold <= '{key: i_in.key, run: r_root.run};
            end
        end else if (i_op.rm_ld) begin
            r_hold <= r_rd_a;
        end else if (i_op.up_cmp && !o_sts.up_stop) begin
            r_pos <= w_parent;
        end else if (i_op.dn_cmp && !o_sts.dn_stop) begin
            r_pos <= w_child_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_op.fin && o_sts.out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        w_out            = r_pend;
        w_out.fetch_run  = w_empty ? '0 : r_root.run;
        w_out.heap_empty = w_empty;
    end

    always_ff @(posedge i_clk) begin
        if (i_op.fin && o_sts.out_free) begin
            r_out <= w_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: rtl/core/heap_kway_merge.sv
// Sequence after accept: clear and refused commands go straight to the result register;
//   insert reads and compares once per level climbed toward the root; pop-replace does the
//   same per level descended; pop-remove first loads the last entry into the hole.
// Throughput: one transaction at a time, set by the heap memory's read-compare-write
//   loop per level, and held longer while a full result register is held by i_out_stall.
//   Next transaction taken once the result is loaded.
// Reset (synchronous, active low) empties the heap and zeroes the output position.
module heap_kway_merge #(
    parameter int MAX_SOURCES = hkm_pkg::HKM_MAX_SOURCES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  hkm_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output hkm_pkg::t_out o_out
);
    import hkm_pkg::*;

    t_dp_op  w_op;
    t_dp_sts w_sts;

    hkm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_op       (w_op)
    );

    hkm_datapath #(
        .MAX_SOURCES (MAX_SOURCES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_op        (w_op),
        .o_sts       (w_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    // a refused insert means the heap was full, so it cannot read back empty
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == ST_FULL) |-> !o_out.heap_empty)
        else $error("full-heap refusal reported with empty heap");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == ST_EMPTY) |-> (o_out.heap_empty && !o_out.emit_valid))
        else $error("empty-heap pop reported a non-empty heap or an emit");

    // the input is stalled in the cycle after every acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted back to back");

endmodule

// File: verif/heap_kway_merge_tb.sv
// Self-checking testbench for the heap_kway_merge k-way merge scheduler.
module heap_kway_merge_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hkm_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int LONG_HOLD   = 400;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in        = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out;

    heap_kway_merge u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // Heap mirror: entries, per-run offsets, count and output position
    logic [KEY_W-1:0]    mirror_keys  [HKM_MAX_SOURCES];
    logic [RUN_W-1:0]    heap_runs    [HKM_MAX_SOURCES];
    logic [OFFSET_W-1:0] run_offsets  [RUN_SLOTS];
    int                  mirror_count = 0;
    logic [POS_W-1:0]    out_pos      = '0;

    t_out pending_results[$];

    int  sent_count    = 0;
    int  mismatches    = 0;
    int  emit_count    = 0;
    int  full_refusals = 0;
    int  empty_pops    = 0;
    int  cycle_count   = 0;
    bit  tail_quiet    = 1'b0;
    bit  long_hold_req = 1'b0;
    int  hold_left     = 0;
    int  burst_left    = 0;
    int  free_left     = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void heap_swap(int a, int b);
        logic [KEY_W-1:0] tk;
        logic [RUN_W-1:0] tr;
        tk = mirror_keys[a];
        tr = heap_runs[a];
        mirror_keys[a] = mirror_keys[b];
        heap_runs[a] = heap_runs[b];
        mirror_keys[b] = tk;
        heap_runs[b] = tr;
    endfunction

    // Ties move down: stop only when the chosen child is strictly greater
    function automatic void sift_down_from(int p);
        int c;
        while (2 * p + 1 < mirror_count) begin
            c = 2 * p + 1;
            if (c + 1 < mirror_count && mirror_keys[c] > mirror_keys[c + 1]) c++;
            if (mirror_keys[c] > mirror_keys[p]) break;
            heap_swap(c, p);
            p = c;
        end
    endfunction

    function automatic t_out heap_predict(t_in t);
        t_out             r;
        int               p;
        int               par;
        logic [RUN_W-1:0] rr;
        r = '0;
        r.status = ST_OK;
        case (t.cmd)
            CMD_CLEAR: begin
                mirror_count = 0;
                out_pos      = '0;
            end
            CMD_INSERT: begin
                if (mirror_count >= HKM_MAX_SOURCES) begin
                    r.status = ST_FULL;
                end else begin
                    p = mirror_count;
                    mirror_keys[p] = t.key;
                    heap_runs[p] = t.run_number;
                    run_offsets[t.run_number] = t.start_offset;
                    mirror_count++;
                    while (p > 0) begin
                        par = (p - 1) / 2;
                        if (mirror_keys[par] <= mirror_keys[p]) break;
                        heap_swap(par, p);
                        p = par;
                    end
                    sift_down_from(p);
                end
            end
            default: begin
                if (mirror_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    rr             = heap_runs[0];
                    r.emit_valid   = 1'b1;
                    r.out_key      = mirror_keys[0];
                    r.out_run      = rr;
                    r.out_offset   = run_offsets[rr];
                    r.out_position = out_pos;
                    out_pos++;
                    run_offsets[rr]++;
                    if (t.cmd == CMD_POP_REPLACE) begin
                        mirror_keys[0] = t.key;
                    end else begin
                        mirror_keys[0] = mirror_keys[mirror_count - 1];
                        heap_runs[0] = heap_runs[mirror_count - 1];
                        mirror_count--;
                    end
                    sift_down_from(0);
                end
            end
        endcase
        r.fetch_run  = (mirror_count > 0) ? heap_runs[0] : '0;
        r.heap_empty = (mirror_count == 0);
        return r;
    endfunction

    function automatic t_in make_item(t_cmd c, logic [KEY_W-1:0] k, logic [RUN_W-1:0] run,
                                      logic [OFFSET_W-1:0] off);
        t_in t;
        t.cmd          = c;
        t.key          = k;
        t.run_number   = run;
        t.start_offset = off;
        return t;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        case ($urandom_range(0, 3))
            0:       k = $urandom_range(0, 7);            // frequent ties
            1:       k = 32'hFFFF_FFF8 + $urandom_range(0, 7);
            default: k = $urandom;
        endcase
        return k;
    endfunction

    function automatic logic [OFFSET_W-1:0] pick_offset();
        logic [OFFSET_W-1:0] off;
        if ($urandom_range(0, 3) == 0) off = 32'hFFFF_FFFC + $urandom_range(0, 3);
        else off = $urandom;
        return off;
    endfunction

    // Sends one transaction; predicts its result at the accepting edge
    task automatic send_cmd(input t_in item);
        int gap;
        if (!tail_quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(heap_predict(item));
        sent_count++;
    endtask

    // Drops valid first so the last transaction is not offered again
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (act !== exp) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no transaction outstanding: %p", o_out);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("emit_valid",   32'(want.emit_valid),   32'(o_out.emit_valid));
                check_field("out_key",      want.out_key,           o_out.out_key);
                check_field("out_run",      32'(want.out_run),      32'(o_out.out_run));
                check_field("out_offset",   want.out_offset,        o_out.out_offset);
                check_field("out_position", want.out_position,      o_out.out_position);
                check_field("fetch_run",    32'(want.fetch_run),    32'(o_out.fetch_run));
                check_field("heap_empty",   32'(want.heap_empty),   32'(o_out.heap_empty));
                check_field("status",       32'(want.status),       32'(o_out.status));
                if (want.emit_valid) emit_count++;
                if (want.status == ST_FULL) full_refusals++;
                if (want.status == ST_EMPTY) empty_pops++;
            end
        end
    end

    // Receiver: random stall bursts separated by free stretches, one long hold, or no stall once the tail is quiet
    always @(negedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (tail_quiet) begin
            i_out_stall <= 1'b0;
        end else if (burst_left > 0) begin
            burst_left--;
            i_out_stall <= 1'b1;
        end else if (free_left > 0) begin
            free_left--;
            i_out_stall <= 1'b0;
        end else begin
            burst_left = $urandom_range(0, 9);
            free_left  = $urandom_range(0, 40);
            i_out_stall <= 1'b1;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("heap_kway_merge test failed");
        $finish;
    end

    task automatic test_empty_heap();
        send_cmd(make_item(CMD_POP_REPLACE, 32'h1234_5678, 4'd5, 32'h0));
        send_cmd(make_item(CMD_POP_REMOVE, '0, '0, '0));
        send_cmd(make_item(CMD_CLEAR, '1, '1, '1));
    endtask

    // Fill to capacity with ties, extremes and a repeated run, then pop across the wrap
    task automatic test_full_heap_and_ties();
        int i;
        send_cmd(make_item(CMD_INSERT, 32'h0, 4'd15, 32'hFFFF_FFFF));
        send_cmd(make_item(CMD_INSERT, 32'hFFFF_FFFF, 4'd0, 32'h0));
        for (i = 2; i < HKM_MAX_SOURCES; i++) begin
            send_cmd(make_item(CMD_INSERT, 32'(100 * (i % 4)),
                               (i == HKM_MAX_SOURCES - 1) ? 4'd3 : 4'(i), 32'(i * 3)));
        end
        send_cmd(make_item(CMD_INSERT, 32'd5, 4'd1, 32'd9));
        send_cmd(make_item(CMD_POP_REPLACE, 32'h0, '0, '0));
        send_cmd(make_item(CMD_POP_REPLACE, 32'hFFFF_FFFF, '0, '0));
        send_cmd(make_item(CMD_POP_REMOVE, '0, '0, '0));
        send_cmd(make_item(CMD_POP_REMOVE, '0, '0, '0));
        send_cmd(make_item(CMD_CLEAR, '0, '0, '0));
    endtask

    // Mostly well-formed merges: clear, load run heads, pop until drained
    task automatic run_merge_sequences(int n_items);
        int               goal;
        int               runs;
        int               r;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] d;
        goal = sent_count + n_items;
        while (sent_count < goal) begin
            if ($urandom_range(0, 3) != 0) send_cmd(make_item(CMD_CLEAR, $urandom, 4'($urandom),
                                                              $urandom));
            runs = $urandom_range(1, HKM_MAX_SOURCES + 1);
            for (r = 0; r < runs; r++) begin
                send_cmd(make_item(CMD_INSERT, pick_key(),
                                   ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'(r),
                                   pick_offset()));
            end
            while (mirror_count > 0 && sent_count < goal) begin
                if ($urandom_range(0, 11) == 0) begin
                    send_cmd(make_item(t_cmd'($urandom_range(0, 3)), $urandom, 4'($urandom),
                                       $urandom));
                end else if ($urandom_range(0, 4) == 0) begin
                    send_cmd(make_item(CMD_POP_REMOVE, $urandom, 4'($urandom), $urandom));
                end else begin
                    if ($urandom_range(0, 7) == 0) begin
                        k = pick_key();
                    end else begin
                        d = $urandom >> $urandom_range(4, 31);
                        k = (mirror_keys[0] > 32'hFFFF_FFFF - d) ? '1 : mirror_keys[0] + d;
                    end
                    send_cmd(make_item(CMD_POP_REPLACE, k, 4'($urandom), $urandom));
                end
            end
            if ($urandom_range(0, 2) == 0) send_cmd(make_item(
                ($urandom_range(0, 1) != 0) ? CMD_POP_REPLACE : CMD_POP_REMOVE,
                $urandom, 4'($urandom), $urandom));
        end
    endtask

    // Receiver holds off for a long stretch while transactions keep coming
    task automatic test_backpressure();
        long_hold_req = 1'b1;
        run_merge_sequences(150);
    endtask

    task automatic test_drain_pause();
        wait_drained();
        run_merge_sequences(150);
    endtask

    task automatic test_quiet_tail();
        tail_quiet = 1'b1;
        run_merge_sequences(425);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_heap();
        test_full_heap_and_ties();
        run_merge_sequences(1000);
        test_backpressure();
        test_drain_pause();
        test_quiet_tail();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (30) @(posedge i_clk);

        $display("Covered %0d transactions: %0d elements emitted, %0d full-heap inserts,",
                 sent_count, emit_count, full_refusals);
        $display("%0d pops of an empty heap, %0d field mismatches.", empty_pops, mismatches);
        if (mismatches == 0) begin
            $display("heap_kway_merge test passed");
        end else begin
            $display("heap_kway_merge test failed");
        end
        $finish;
    end

endmodule
